// ===== hw/rtl/slt_pkg.sv =====
// slt_pkg: shared constants, operation codes and types of the sorted list table.
// No dependencies; imported by every module of the block.
package slt_pkg;

	localparam int CAPACITY    = 16;
	localparam int VALUE_WIDTH = 32;
	localparam int IDX_W       = $clog2(CAPACITY);
	localparam int CNT_W       = $clog2(CAPACITY + 1);
	localparam int FIELD_W     = 5;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_DELETE = 2'd1;
	localparam logic [1:0] OP_FIND   = 2'd2;

	typedef logic [VALUE_WIDTH-1:0] val_t;
	typedef logic [IDX_W-1:0]       idx_t;
	typedef logic [CNT_W-1:0]       cnt_t;

	typedef struct packed {
		logic lt;
		logic eq;
	} cmp_res_t;

endpackage

// ===== hw/rtl/sorted_list_table.sv =====
// sorted_list_table: top level, sequencer around the entry memory and compare unit.
// Depends on slt_pkg, slt_store and slt_cmp.
//
// Usage:
//   Input channel in_valid/in_ready carries operation and value; output channel
//   out_valid/out_ready returns position, table_full and entry_count, one result
//   per transaction. Entries are kept in ascending signed order in a 16-entry
//   single-port-read memory.
//   Each transaction is handled alone: a scan reads one entry per cycle through
//   the compare unit until the first hit, then insert or delete moves the
//   following entries one place, one entry per cycle, through the same read port.
//   An unused code or an insert into a full table goes straight to the result
//   without a scan. in_ready is high only while the sequencer is idle, from the
//   cycle after the result is loaded, so a new transaction is not taken before
//   the previous one has been loaded into the output register.
//   A finished result waits in the output register; a new transaction is taken
//   meanwhile, and its result is held back until the receiver takes the previous one.
//   Reset empties the table (count to zero) and clears the output register.
module sorted_list_table (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  operation,
	input  logic signed [31:0]          value,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [slt_pkg::FIELD_W-1:0] position,
	output logic                        table_full,
	output logic [slt_pkg::FIELD_W-1:0] entry_count
);
	import slt_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_SHIFT = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0]         state_q;
	logic [1:0]         op_q;
	val_t               key_q;
	cnt_t               count_q;
	cnt_t               scan_q;
	cnt_t               sh_q;
	cnt_t               idx_q;
	logic               found_q;
	logic               full_q;
	logic               rvld_s1;
	cnt_t               rtag_s1;
	logic               out_valid_q;
	logic [FIELD_W-1:0] position_q;
	logic               table_full_q;
	logic [FIELD_W-1:0] entry_count_q;

	logic     rd_en;
	idx_t     rd_addr;
	cnt_t     rd_tag;
	logic     wr_en;
	idx_t     wr_addr;
	val_t     wr_data;
	val_t     rd_data;
	cmp_res_t cmp;
	logic     hit;
	logic     is_ins;
	logic     out_load;

	slt_store u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	slt_cmp u_cmp (
		.entry (rd_data),
		.key   (key_q),
		.res   (cmp)
	);

	assign is_ins   = op_q == OP_INSERT;
	assign hit      = (state_q == ST_SCAN) && rvld_s1 && (is_ins ? !cmp.lt : cmp.eq);
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	always_comb begin
		rd_en   = 1'b0;
		rd_tag  = scan_q;
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = rd_data;
		unique case (state_q)
			ST_SCAN: begin
				if (!hit && scan_q < count_q) begin
					rd_en = 1'b1;
				end
			end
			ST_SHIFT: begin
				if (is_ins) begin
					if (rvld_s1) begin
						wr_en   = 1'b1;
						wr_addr = idx_t'(rtag_s1 + 1'b1);
					end
					if (sh_q > idx_q) begin
						rd_en  = 1'b1;
						rd_tag = sh_q - 1'b1;
					end else if (!rvld_s1) begin
						wr_en   = 1'b1;
						wr_addr = idx_q[IDX_W-1:0];
						wr_data = key_q;
					end
				end else begin
					if (rvld_s1) begin
						wr_en   = 1'b1;
						wr_addr = idx_t'(rtag_s1 - 1'b1);
					end
					if (sh_q < count_q) begin
						rd_en  = 1'b1;
						rd_tag = sh_q;
					end
				end
			end
			ST_IDLE, ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	assign rd_addr = rd_tag[IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_INSERT;
			key_q   <= '0;
			count_q <= '0;
			scan_q  <= '0;
			sh_q    <= '0;
			idx_q   <= '0;
			found_q <= 1'b0;
			full_q  <= 1'b0;
			rvld_s1 <= 1'b0;
			rtag_s1 <= '0;
		end else begin
			rvld_s1 <= rd_en;
			rtag_s1 <= rd_tag;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						op_q    <= operation;
						key_q   <= val_t'(value);
						scan_q  <= '0;
						found_q <= 1'b0;
						full_q  <= 1'b0;
						if (operation == OP_INSERT && count_q == cnt_t'(CAPACITY)) begin
							full_q  <= 1'b1;
							state_q <= ST_DONE;
						end else if (operation == OP_INSERT || operation == OP_DELETE
								|| operation == OP_FIND) begin
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_SCAN: begin
					if (rd_en) begin
						scan_q <= scan_q + 1'b1;
					end
					if (hit) begin
						found_q <= 1'b1;
						idx_q   <= rtag_s1;
						sh_q    <= is_ins ? count_q : cnt_t'(rtag_s1 + 1'b1);
						state_q <= (op_q == OP_FIND) ? ST_DONE : ST_SHIFT;
					end else if (scan_q >= count_q && !rvld_s1) begin
						idx_q   <= count_q;
						sh_q    <= count_q;
						state_q <= is_ins ? ST_SHIFT : ST_DONE;
					end
				end
				ST_SHIFT: begin
					if (is_ins) begin
						if (sh_q > idx_q) begin
							sh_q <= sh_q - 1'b1;
						end else if (!rvld_s1) begin
							count_q <= count_q + 1'b1;
							state_q <= ST_DONE;
						end
					end else begin
						if (sh_q < count_q) begin
							sh_q <= sh_q + 1'b1;
						end else if (!rvld_s1) begin
							count_q <= count_q - 1'b1;
							state_q <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q   <= 1'b0;
			position_q    <= '0;
			table_full_q  <= 1'b0;
			entry_count_q <= '0;
		end else if (out_load) begin
			out_valid_q   <= 1'b1;
			position_q    <= (found_q && !is_ins) ? FIELD_W'(idx_q + 1'b1) : '0;
			table_full_q  <= full_q;
			entry_count_q <= FIELD_W'(count_q);
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign in_ready    = state_q == ST_IDLE;
	assign out_valid   = out_valid_q;
	assign position    = position_q;
	assign table_full  = table_full_q;
	assign entry_count = entry_count_q;

endmodule

// ===== hw/rtl/slt_store.sv =====
// slt_store: entry memory, one write port and one read port with registered data.
// Depends on slt_pkg.
module slt_store (
	input  logic          clk,
	input  logic          wr_en,
	input  slt_pkg::idx_t wr_addr,
	input  slt_pkg::val_t wr_data,
	input  logic          rd_en,
	input  slt_pkg::idx_t rd_addr,
	output slt_pkg::val_t rd_data
);
	import slt_pkg::*;

	val_t mem_q [CAPACITY];
	val_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== hw/rtl/slt_cmp.sv =====
// slt_cmp: shared signed compare unit, stored entry against the search key.
// Depends on slt_pkg.
module slt_cmp (
	input  slt_pkg::val_t    entry,
	input  slt_pkg::val_t    key,
	output slt_pkg::cmp_res_t res
);
	import slt_pkg::*;

	always_comb begin
		res.lt = $signed(entry) < $signed(key);
		res.eq = entry == key;
	end

endmodule

// ===== hw/rtl/slt_checker.sv =====
// slt_checker: port-level assertions for sorted_list_table, bound to the top level.
// Depends on slt_pkg and sorted_list_table.
module slt_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [slt_pkg::FIELD_W-1:0] position,
	input logic                        table_full,
	input logic [slt_pkg::FIELD_W-1:0] entry_count
);
	import slt_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready after accepted transaction");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> entry_count <= FIELD_W'(CAPACITY))
		else $error("entry count beyond capacity");

	a_full_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && table_full |-> position == '0
			&& entry_count == FIELD_W'(CAPACITY))
		else $error("rejected insert with bad fields");

	a_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> {1'b0, position} <= {1'b0, entry_count} + 1'b1)
		else $error("position beyond table");

endmodule

bind sorted_list_table slt_checker u_slt_checker (.*);

// ===== dv/sorted_list_table_tb.sv =====
// Testbench for sorted_list_table: directed and random insert, delete and find
// transactions checked against a behavioural model of the ordered table.
// Depends on slt_pkg and the sorted_list_table RTL.
`timescale 1ns / 1ps

module sorted_list_table_tb;
	import slt_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int PHASE_ITEMS = 425;

	typedef struct packed {
		logic [1:0]         op;
		logic signed [31:0] value;
	} table_op_t;

	typedef struct packed {
		logic [FIELD_W-1:0] position;
		logic               table_full;
		logic [FIELD_W-1:0] entry_count;
	} table_result_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [1:0]          operation;
	logic signed [31:0]  value;
	logic                out_valid;
	logic                out_ready;
	logic [FIELD_W-1:0]  position;
	logic                table_full;
	logic [FIELD_W-1:0]  entry_count;

	table_op_t           pending_ops[$];
	table_result_t       expected_results[$];
	logic signed [31:0]  recent_values[$];
	logic signed [31:0]  shadow_entries[CAPACITY];
	int                  shadow_count;
	int                  send_idle_pct;
	int                  recv_stall_pct;
	int                  sent_total;
	int                  taken_total;
	int                  mismatches;
	logic                in_taken;

	sorted_list_table uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.operation   (operation),
		.value       (value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.position    (position),
		.table_full  (table_full),
		.entry_count (entry_count)
	);

	always #6 clk = ~clk;

	task automatic flag_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0d, expected %0d (transaction %0d)",
			what, got, want, taken_total - expected_results.size());
		mismatches++;
	endtask

	function automatic int first_equal(input logic signed [31:0] v);
		int slot;
		slot = 0;
		while (slot < shadow_count && shadow_entries[slot] != v)
			slot++;
		return slot;
	endfunction

	function automatic table_result_t apply_table_op(input table_op_t t);
		table_result_t r;
		int slot;
		r = '0;
		slot = 0;
		case (t.op)
			OP_INSERT: begin
				if (shadow_count >= CAPACITY) begin
					r.table_full = 1'b1;
				end else begin
					while (slot < shadow_count && shadow_entries[slot] < t.value)
						slot++;
					for (int k = shadow_count; k > slot; k--)
						shadow_entries[k] = shadow_entries[k-1];
					shadow_entries[slot] = t.value;
					shadow_count++;
				end
			end
			OP_DELETE: begin
				slot = first_equal(t.value);
				if (slot < shadow_count) begin
					r.position = FIELD_W'(slot + 1);
					for (int k = slot; k + 1 < shadow_count; k++)
						shadow_entries[k] = shadow_entries[k+1];
					shadow_count--;
				end
			end
			OP_FIND: begin
				slot = first_equal(t.value);
				if (slot < shadow_count)
					r.position = FIELD_W'(slot + 1);
			end
			default: ;
		endcase
		r.entry_count = FIELD_W'(shadow_count);
		return r;
	endfunction

	task automatic queue_op(input logic [1:0] op, input logic signed [31:0] v);
		table_op_t t;
		t.op = op;
		t.value = v;
		pending_ops.push_back(t);
		if (op == OP_INSERT) begin
			recent_values.push_back(v);
			if (recent_values.size() > 64)
				void'(recent_values.pop_front());
		end
	endtask

	function automatic logic signed [31:0] random_value(input logic [1:0] op);
		int roll;
		int v;
		roll = $urandom_range(0, 99);
		if (op != OP_INSERT && recent_values.size() > 0 && roll < 50)
			return recent_values[$urandom_range(0, recent_values.size() - 1)];
		roll = $urandom_range(0, 99);
		if (roll < 65) begin
			v = int'($urandom_range(0, 15)) - 8;
			return v;
		end
		if (roll < 75) begin
			case ($urandom_range(0, 3))
				0: return 32'sh8000_0000;
				1: return 32'sh7fff_ffff;
				2: return 32'sh8000_0001;
				default: return 32'sh7fff_fffe;
			endcase
		end
		return $urandom();
	endfunction

	function automatic logic [1:0] random_op(input int ins_pct, input int del_pct);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 3)
			return OP_UNUSED;
		if (roll < 3 + ins_pct)
			return OP_INSERT;
		if (roll < 3 + ins_pct + del_pct)
			return OP_DELETE;
		return OP_FIND;
	endfunction

	task automatic queue_random_phase(input int count);
		int queued;
		int burst;
		int ins_pct;
		int del_pct;
		logic [1:0] op;
		queued = 0;
		while (queued < count) begin
			case ($urandom_range(0, 2))
				0: begin ins_pct = 70; del_pct = 15; end
				1: begin ins_pct = 15; del_pct = 65; end
				default: begin ins_pct = 40; del_pct = 35; end
			endcase
			burst = $urandom_range(10, 50);
			for (int n = 0; n < burst && queued < count; n++) begin
				op = random_op(ins_pct, del_pct);
				queue_op(op, random_value(op));
				queued++;
			end
		end
	endtask

	task automatic wait_drained();
		@(negedge clk);
		while (pending_ops.size() != 0 || taken_total != sent_total ||
			expected_results.size() != 0)
			@(negedge clk);
	endtask

	// driver: new transaction only once the previous one has been taken
	always @(negedge clk) begin : drive_inputs
		table_op_t nxt;
		if (arst_n) begin
			if (!in_valid || in_taken) begin
				if (pending_ops.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					nxt = pending_ops.pop_front();
					in_valid  <= 1'b1;
					operation <= nxt.op;
					value     <= nxt.value;
					sent_total++;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin : watch_ports
		table_op_t t;
		table_result_t want;
		in_taken <= in_valid && in_ready;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				t.op = operation;
				t.value = value;
				expected_results.push_back(apply_table_op(t));
				taken_total++;
			end
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					flag_mismatch("result with nothing outstanding", position, 0);
				end else begin
					want = expected_results.pop_front();
					if (position !== want.position)
						flag_mismatch("position", position, want.position);
					if (table_full !== want.table_full)
						flag_mismatch("table_full", table_full, want.table_full);
					if (entry_count !== want.entry_count)
						flag_mismatch("entry_count", entry_count, want.entry_count);
				end
			end
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = OP_INSERT;
		value = '0;
		out_ready = 1'b0;
		in_taken = 1'b0;
		shadow_count = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		sent_total = 0;
		taken_total = 0;
		mismatches = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty table, then fill to capacity with extremes and duplicates
		queue_op(OP_FIND, 32'sd0);
		queue_op(OP_DELETE, 32'sd5);
		queue_op(OP_UNUSED, 32'sd0);
		queue_op(OP_INSERT, 32'sd0);
		queue_op(OP_INSERT, 32'sh7fff_ffff);
		queue_op(OP_INSERT, 32'sh8000_0000);
		queue_op(OP_INSERT, -32'sd1);
		queue_op(OP_INSERT, 32'sd1);
		queue_op(OP_INSERT, 32'sd0);
		queue_op(OP_INSERT, 32'sd5);
		queue_op(OP_INSERT, -32'sd5);
		queue_op(OP_INSERT, 32'sh7fff_fffe);
		queue_op(OP_INSERT, 32'sh8000_0001);
		queue_op(OP_INSERT, 32'sd0);
		queue_op(OP_INSERT, 32'sd100);
		queue_op(OP_INSERT, -32'sd100);
		queue_op(OP_INSERT, 32'sd3);
		queue_op(OP_INSERT, -32'sd3);
		queue_op(OP_INSERT, 32'sd2);
		queue_op(OP_INSERT, 32'sd9);
		queue_op(OP_FIND, 32'sh8000_0000);
		queue_op(OP_FIND, 32'sh7fff_ffff);
		queue_op(OP_UNUSED, -32'sd1);
		queue_op(OP_DELETE, 32'sd0);
		queue_op(OP_DELETE, 32'sd12345);
		wait_drained();

		for (int phase = 0; phase < 4; phase++) begin
			@(posedge clk);
			send_idle_pct  = (phase == 1 || phase == 3) ? ((phase == 1) ? 56 : 12) : 0;
			recv_stall_pct = (phase == 2 || phase == 3) ? ((phase == 2) ? 56 : 12) : 0;
			queue_random_phase(PHASE_ITEMS);
			wait_drained();
		end

		repeat (2 * CAPACITY + 10) @(posedge clk);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#12000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== sorted_list_table.f =====
hw/rtl/slt_pkg.sv
hw/rtl/slt_store.sv
hw/rtl/slt_cmp.sv
hw/rtl/sorted_list_table.sv
hw/rtl/slt_checker.sv
dv/sorted_list_table_tb.sv
